FILE: design/cpr_pkg.sv
// ---------------------------------------------------------------------------
// cpr_pkg: shared constants for the contact pair resolver
// Field widths, body type code, threshold reset, ratio constants and divider depth.
// ---------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int TYPE_W   = 2;
  localparam int MASS_W   = 16;
  localparam int VEC_W    = 48;
  localparam int NRM_W    = 16;
  localparam int THR_W    = 15;

  // body kinds below this code count as fixed
  localparam logic [TYPE_W-1:0] TYPE_DYNAMIC = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 15'd11469;  // 0.7 in Q1.14

  // mass ratio: unsigned Q0.16, one extra bit to hold 1.0
  localparam int RATIO_W = MASS_W + 1;
  localparam logic [RATIO_W-1:0] RATIO_HALF = 17'd32768;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'd65536;

  // one quotient bit per divider stage
  localparam int DIV_STEPS = RATIO_W;

endpackage

`default_nettype wire

FILE: design/cpr_div.sv
// ---------------------------------------------------------------------------
// cpr_div: pipelined restoring divider for the mass ratio
// quo = floor(num * 2^16 / den), one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cpr_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [cpr_pkg::MASS_W-1:0]      num,
  input  logic [cpr_pkg::RATIO_W-1:0]     den,
  output logic [cpr_pkg::RATIO_W-1:0]     quo,
  output logic                            rem_nz
);
  import cpr_pkg::*;

  logic [RATIO_W-1:0] rem_q  [DIV_STEPS];
  logic [RATIO_W-1:0] den_q  [DIV_STEPS];
  logic [RATIO_W-1:0] q_q    [DIV_STEPS];
  logic [RATIO_W-1:0] rem_next [DIV_STEPS];
  logic [RATIO_W-1:0] q_next   [DIV_STEPS];
  logic [RATIO_W:0]   trial    [DIV_STEPS];
  logic               ge       [DIV_STEPS];

  always_comb begin
    // first step: num <= den, so the top bit needs no shift
    trial[0]  = {2'b00, num};
    ge[0]     = trial[0] >= {1'b0, den};
    rem_next[0] = ge[0] ? RATIO_W'(trial[0] - {1'b0, den}) : RATIO_W'(trial[0]);
    q_next[0] = '0;
    q_next[0][DIV_STEPS-1] = ge[0];
    for (int k = 1; k < DIV_STEPS; k++) begin
      trial[k]  = {rem_q[k-1], 1'b0};
      ge[k]     = trial[k] >= {1'b0, den_q[k-1]};
      rem_next[k] = ge[k] ? RATIO_W'(trial[k] - {1'b0, den_q[k-1]})
                          : RATIO_W'(trial[k]);
      q_next[k] = q_q[k-1];
      q_next[k][DIV_STEPS-1-k] = ge[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0] <= den;
      rem_q[0] <= rem_next[0];
      q_q[0]   <= q_next[0];
      for (int k = 1; k < DIV_STEPS; k++) begin
        den_q[k] <= den_q[k-1];
        rem_q[k] <= rem_next[k];
        q_q[k]   <= q_next[k];
      end
    end
  end

  assign quo    = q_q[DIV_STEPS-1];
  assign rem_nz = |rem_q[DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: design/contact_pair_resolver_unit.sv
// ---------------------------------------------------------------------------
// contact_pair_resolver_unit: inelastic contact resolution for one body pair
// Throughput: one request per cycle unless a stalled result holds the pipe; the 17-stage ratio divider sets depth.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, sync): clears all valid bits, ground_threshold back to 0.7.
// ---------------------------------------------------------------------------
`default_nettype none

module contact_pair_resolver_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // ground threshold register, Q1.14
  input  logic                          cfg_wr_en,
  input  logic [cpr_pkg::THR_W-1:0]     cfg_wr_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cpr_pkg::TYPE_W-1:0]    type_a,
  input  logic [cpr_pkg::TYPE_W-1:0]    type_b,
  input  logic [cpr_pkg::MASS_W-1:0]    mass_a,
  input  logic [cpr_pkg::MASS_W-1:0]    mass_b,
  input  logic [cpr_pkg::VEC_W-1:0]     position_a,
  input  logic [cpr_pkg::VEC_W-1:0]     position_b,
  input  logic [cpr_pkg::VEC_W-1:0]     velocity_a,
  input  logic [cpr_pkg::VEC_W-1:0]     velocity_b,
  input  logic [cpr_pkg::VEC_W-1:0]     normal_vec,
  input  logic [cpr_pkg::MASS_W-1:0]    depth,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpr_pkg::VEC_W-1:0]     new_position_a,
  output logic [cpr_pkg::VEC_W-1:0]     new_position_b,
  output logic [cpr_pkg::VEC_W-1:0]     new_velocity_a,
  output logic [cpr_pkg::VEC_W-1:0]     new_velocity_b,
  output logic                          grounded_a,
  output logic                          grounded_b
);
  import cpr_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int EXT_W = (3 * CW > VEC_W) ? 3 * CW : VEC_W;  // packed lanes, padded
  localparam int UW    = CW + 1;        // relative velocity
  localparam int PW    = CW + 17;       // u * n
  localparam int DW    = CW + 19;       // dot product
  localparam int DDW   = CW + 6;        // normal velocity, Q8.8
  localparam int NPW   = 32;            // n * depth
  localparam int NDW   = CW + 22;       // n * d
  localparam int RW    = RATIO_W + 1;   // signed ratio
  localparam int PPW   = NPW + RW;
  localparam int VPW   = NDW + RW;
  localparam int SW    = CW + 8;        // corrected value before saturation
  localparam int NST   = DIV_STEPS + 4; // pipeline depth
  localparam int DLY   = DIV_STEPS - 4; // delay line s5..s17

  typedef logic signed [CW-1:0] crd_t;

  typedef struct {
    logic fa, fb, tz, ga, gb;
    crd_t pa [3];
    crd_t pb [3];
    crd_t va [3];
    crd_t vb [3];
    logic signed [NRM_W-1:0] n [3];
    logic [MASS_W-1:0] dep;
  } base_t;

  typedef struct {
    logic fa, fb, tz, cond, ga, gb;
    crd_t pa [3];
    crd_t pb [3];
    crd_t va [3];
    crd_t vb [3];
    logic signed [NPW-1:0] ndep [3];
    logic signed [NDW-1:0] nd [3];
  } late_t;

  typedef struct {
    logic ga, gb;
    crd_t pa [3];
    crd_t pb [3];
    crd_t va [3];
    crd_t vb [3];
  } tail_t;

  // ---- control: one enable for the whole pipe ----------------------------
  logic [NST:1] vld;
  logic         en;

  assign en       = !(vld[NST] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], in_valid};
    end
  end

  // ---- ground threshold register ------------------------------------------
  logic [THR_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // ---- s1: unpack, fixed flags, grounding and downward clamp --------------
  logic [EXT_W-1:0] ext_pa, ext_pb, ext_va, ext_vb;
  base_t            c1, s1;
  logic signed [NRM_W:0] ny_x, thr_x;
  logic [MASS_W:0]  total;

  always_comb begin
    ext_pa = EXT_W'(position_a);
    ext_pb = EXT_W'(position_b);
    ext_va = EXT_W'(velocity_a);
    ext_vb = EXT_W'(velocity_b);
    total  = {1'b0, mass_a} + {1'b0, mass_b};
    c1.fa  = type_a < TYPE_DYNAMIC;
    c1.fb  = type_b < TYPE_DYNAMIC;
    c1.tz  = total == '0;
    c1.dep = depth;
    for (int i = 0; i < 3; i++) begin
      c1.pa[i] = ext_pa[i*CW +: CW];
      c1.pb[i] = ext_pb[i*CW +: CW];
      c1.va[i] = ext_va[i*CW +: CW];
      c1.vb[i] = ext_vb[i*CW +: CW];
      c1.n[i]  = normal_vec[i*NRM_W +: NRM_W];
    end
    // A grounded: normal points down from A; B grounded: points up into B
    ny_x  = {c1.n[1][NRM_W-1], c1.n[1]};
    thr_x = $signed({2'b00, thr});
    c1.ga = !c1.fa && (ny_x < -thr_x);
    c1.gb = !c1.fb && (ny_x > thr_x);
    if (c1.ga && c1.va[1] < 0) c1.va[1] = '0;
    if (c1.gb && c1.vb[1] < 0) c1.vb[1] = '0;
  end

  // mass ratio divider runs alongside s1..s17
  logic [RATIO_W-1:0] quo;
  logic               rem_nz;

  cpr_div u_div (
    .clk    (clk),
    .en     (en),
    .num    (mass_b),
    .den    (total),
    .quo    (quo),
    .rem_nz (rem_nz)
  );

  always_ff @(posedge clk) begin
    if (en) s1 <= c1;
  end

  // ---- s2: velocity operand, u*n and n*depth ------------------------------
  base_t                 s2;
  logic signed [PW-1:0]  s2_un [3];
  logic signed [NPW-1:0] s2_ndep [3];
  logic signed [UW-1:0]  u [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!s1.fa && !s1.fb)  u[i] = UW'(s1.vb[i]) - UW'(s1.va[i]);
      else if (!s1.fa)       u[i] = UW'(s1.va[i]);
      else if (!s1.fb)       u[i] = UW'(s1.vb[i]);
      else                   u[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1;
      for (int i = 0; i < 3; i++) begin
        s2_un[i]   <= u[i] * s1.n[i];
        s2_ndep[i] <= s1.n[i] * $signed({1'b0, s1.dep});
      end
    end
  end

  // ---- s3: dot product ----------------------------------------------------
  base_t                 s3;
  logic signed [NPW-1:0] s3_ndep [3];
  logic signed [DW-1:0]  s3_dot;

  always_ff @(posedge clk) begin
    if (en) begin
      s3      <= s2;
      s3_ndep <= s2_ndep;
      s3_dot  <= DW'(s2_un[0]) + DW'(s2_un[1]) + DW'(s2_un[2]);
    end
  end

  // ---- s4: approach test and rounded normal velocity ----------------------
  base_t                 s4;
  logic signed [NPW-1:0] s4_ndep [3];
  logic signed [DDW-1:0] s4_d;
  logic                  s4_cond;
  logic signed [DW-1:0]  d_bias, d_full;
  logic                  cond;

  always_comb begin
    d_bias = s3_dot[DW-1] ? DW'((1 << 13) - 1) : DW'(1 << 13);
    d_full = (s3_dot + d_bias) >>> 14;
    if (!s3.fa && !s3.fb)  cond = s3_dot[DW-1];
    else if (!s3.fa)       cond = !s3_dot[DW-1] && (s3_dot != '0);
    else if (!s3.fb)       cond = s3_dot[DW-1];
    else                   cond = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4      <= s3;
      s4_ndep <= s3_ndep;
      s4_d    <= DDW'(d_full);
      s4_cond <= cond;
    end
  end

  // ---- s5..s17: n*d, then wait for the ratio ------------------------------
  late_t late [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      late[0].fa   <= s4.fa;
      late[0].fb   <= s4.fb;
      late[0].tz   <= s4.tz;
      late[0].cond <= s4_cond;
      late[0].ga   <= s4.ga;
      late[0].gb   <= s4.gb;
      late[0].pa   <= s4.pa;
      late[0].pb   <= s4.pb;
      late[0].va   <= s4.va;
      late[0].vb   <= s4.vb;
      late[0].ndep <= s4_ndep;
      for (int i = 0; i < 3; i++) begin
        late[0].nd[i] <= s4.n[i] * s4_d;
      end
      for (int k = 1; k < DLY; k++) begin
        late[k] <= late[k-1];
      end
    end
  end

  // ---- s18: scale by mass ratio (1.0 for the single moving body) ----------
  late_t                 lt;
  logic [RATIO_W-1:0]    ra, rb;
  logic signed [RW-1:0]  ra_s, rb_s;
  logic                  dyn;
  tail_t                 s18;
  logic signed [PPW-1:0] s18_ppa [3];
  logic signed [PPW-1:0] s18_ppb [3];
  logic signed [VPW-1:0] s18_pva [3];
  logic signed [VPW-1:0] s18_pvb [3];
  logic                  s18_epa, s18_epb, s18_eva, s18_evb, s18_dyn;

  always_comb begin
    lt  = late[DLY-1];
    dyn = !lt.fa && !lt.fb;
    if (!dyn) begin
      ra = RATIO_ONE;
      rb = RATIO_ONE;
    end else if (lt.tz) begin
      ra = RATIO_HALF;
      rb = RATIO_HALF;
    end else begin
      // floor(ma/T) = 1 - ceil(mb/T)
      ra = quo;
      rb = RATIO_W'(RATIO_ONE - quo - RATIO_W'(rem_nz));
    end
    ra_s = $signed({1'b0, ra});
    rb_s = $signed({1'b0, rb});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s18.ga  <= lt.ga;
      s18.gb  <= lt.gb;
      s18.pa  <= lt.pa;
      s18.pb  <= lt.pb;
      s18.va  <= lt.va;
      s18.vb  <= lt.vb;
      s18_epa <= !lt.fa;
      s18_epb <= !lt.fb;
      s18_eva <= !lt.fa && lt.cond;
      s18_evb <= !lt.fb && lt.cond;
      s18_dyn <= dyn;
      for (int i = 0; i < 3; i++) begin
        s18_ppa[i] <= lt.ndep[i] * ra_s;
        s18_ppb[i] <= lt.ndep[i] * rb_s;
        s18_pva[i] <= lt.nd[i] * ra_s;
        s18_pvb[i] <= lt.nd[i] * rb_s;
      end
    end
  end

  // ---- s19: round by 2^30, ties away from zero ----------------------------
  tail_t                s19;
  logic signed [SW-1:0] s19_dpa [3];
  logic signed [SW-1:0] s19_dpb [3];
  logic signed [SW-1:0] s19_dva [3];
  logic signed [SW-1:0] s19_dvb [3];
  logic signed [PPW-1:0] rpa [3];
  logic signed [PPW-1:0] rpb [3];
  logic signed [VPW-1:0] rva [3];
  logic signed [VPW-1:0] rvb [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rpa[i] = (s18_ppa[i] + (s18_ppa[i][PPW-1] ? PPW'((1 << 29) - 1) : PPW'(1 << 29)))
               >>> 30;
      rpb[i] = (s18_ppb[i] + (s18_ppb[i][PPW-1] ? PPW'((1 << 29) - 1) : PPW'(1 << 29)))
               >>> 30;
      rva[i] = (s18_pva[i] + (s18_pva[i][VPW-1] ? VPW'((1 << 29) - 1) : VPW'(1 << 29)))
               >>> 30;
      rvb[i] = (s18_pvb[i] + (s18_pvb[i][VPW-1] ? VPW'((1 << 29) - 1) : VPW'(1 << 29)))
               >>> 30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s19 <= s18;
      for (int i = 0; i < 3; i++) begin
        s19_dpa[i] <= s18_epa ? SW'(rpa[i]) : '0;
        s19_dpb[i] <= s18_epb ? SW'(rpb[i]) : '0;
        // two dynamic bodies: A gains; single moving A: loses
        s19_dva[i] <= !s18_eva ? '0 : (s18_dyn ? SW'(rva[i]) : -SW'(rva[i]));
        s19_dvb[i] <= s18_evb ? SW'(rvb[i]) : '0;
      end
    end
  end

  // ---- s20: apply corrections ---------------------------------------------
  logic                 s20_ga, s20_gb;
  logic signed [SW-1:0] s20_pa [3];
  logic signed [SW-1:0] s20_pb [3];
  logic signed [SW-1:0] s20_va [3];
  logic signed [SW-1:0] s20_vb [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s20_ga <= s19.ga;
      s20_gb <= s19.gb;
      for (int i = 0; i < 3; i++) begin
        s20_pa[i] <= SW'(s19.pa[i]) - s19_dpa[i];
        s20_pb[i] <= SW'(s19.pb[i]) + s19_dpb[i];
        s20_va[i] <= SW'(s19.va[i]) + s19_dva[i];
        s20_vb[i] <= SW'(s19.vb[i]) - s19_dvb[i];
      end
    end
  end

  // ---- s21: saturate to lane range, output register -----------------------
  function automatic crd_t sat(input logic signed [SW-1:0] x);
    crd_t r;
    if (&x[SW-1:CW-1] || ~|x[SW-1:CW-1]) begin
      r = x[CW-1:0];
    end else begin
      r = {x[SW-1], {(CW-1){~x[SW-1]}}};
    end
    return r;
  endfunction

  tail_t s21;

  always_ff @(posedge clk) begin
    if (en) begin
      s21.ga <= s20_ga;
      s21.gb <= s20_gb;
      for (int i = 0; i < 3; i++) begin
        s21.pa[i] <= sat(s20_pa[i]);
        s21.pb[i] <= sat(s20_pb[i]);
        s21.va[i] <= sat(s20_va[i]);
        s21.vb[i] <= sat(s20_vb[i]);
      end
    end
  end

  // pack lanes, x lowest; bits past the field width drop off
  logic [EXT_W-1:0] o_pa, o_pb, o_va, o_vb;

  always_comb begin
    o_pa = EXT_W'({s21.pa[2], s21.pa[1], s21.pa[0]});
    o_pb = EXT_W'({s21.pb[2], s21.pb[1], s21.pb[0]});
    o_va = EXT_W'({s21.va[2], s21.va[1], s21.va[0]});
    o_vb = EXT_W'({s21.vb[2], s21.vb[1], s21.vb[0]});
  end

  assign new_position_a = o_pa[VEC_W-1:0];
  assign new_position_b = o_pb[VEC_W-1:0];
  assign new_velocity_a = o_va[VEC_W-1:0];
  assign new_velocity_b = o_vb[VEC_W-1:0];
  assign grounded_a     = s21.ga;
  assign grounded_b     = s21.gb;

endmodule

`default_nettype wire
